// ===== rtl/core/cac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current autorange controller package
// Shared types, register indexes and reset values of the autoranger.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int unsigned LimitW  = 23;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CalW    = 16;
  localparam int unsigned CurW    = 24;
  localparam int unsigned RangeW  = 2;
  localparam int unsigned ShuntW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [RangeW-1:0] {
    RANGE_LOW  = 2'd0,
    RANGE_MID  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_LIMIT_LOW    = 3'd0,
    CFG_UP_LIMIT_MID    = 3'd1,
    CFG_DOWN_LIMIT_MID  = 3'd2,
    CFG_DOWN_LIMIT_HIGH = 3'd3,
    CFG_SAMPLES_NEEDED  = 3'd4,
    CFG_CAL_WORD_LOW    = 3'd5,
    CFG_CAL_WORD_MID    = 3'd6,
    CFG_CAL_WORD_HIGH   = 3'd7
  } cfg_idx_e;

  localparam logic [LimitW-1:0] UpLimitLowRst    = 23'd800;
  localparam logic [LimitW-1:0] UpLimitMidRst    = 23'd92000;
  localparam logic [LimitW-1:0] DownLimitMidRst  = 23'd700;
  localparam logic [LimitW-1:0] DownLimitHighRst = 23'd40000;
  localparam logic [CountW-1:0] SamplesNeededRst = 4'd1;
  localparam logic [CalW-1:0]   CalWordLowRst    = 16'd517;
  localparam logic [CalW-1:0]   CalWordMidRst    = 16'd602;
  localparam logic [CalW-1:0]   CalWordHighRst   = 16'd128;

  localparam logic [LimitW-1:0] MagMax = '1;

  typedef struct packed {
    logic [LimitW-1:0] up_limit_low;
    logic [LimitW-1:0] up_limit_mid;
    logic [LimitW-1:0] down_limit_mid;
    logic [LimitW-1:0] down_limit_high;
    logic [CountW-1:0] samples_needed;
    logic [CalW-1:0]   cal_word_low;
    logic [CalW-1:0]   cal_word_mid;
    logic [CalW-1:0]   cal_word_high;
  } cfg_t;

  typedef struct packed {
    logic              force_range;
    logic [LimitW-1:0] magnitude;
    logic [RangeW-1:0] forced_range;
  } item_t;

  typedef struct packed {
    logic              switched;
    logic [CalW-1:0]   cal_word;
    logic [ShuntW-1:0] shunt_select;
    logic [RangeW-1:0] active_range;
  } result_t;

endpackage

// ===== rtl/core/current_autorange_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current autorange controller
// Three-range current autoranger with hysteresis and one-hot shunt select.
//
//   channel   direction  content
//   s_axis    in         tuser: action; tdata: current_ua[23:0], forced_range[25:24]
//   m_axis    out        tdata: active_range, shunt_select, cal_word, switched
//   cfg       in         cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// One transaction per cycle sustained while m_axis_tready is high; an
// accepted input is loaded into the input register, and the result register
// then loads the decision from it.
// Reset puts the block in the high range with a zero count and the
// documented register defaults. A stalled result holds; one more input
// transaction is taken into the input register while the result waits.
// ----------------------------------------------------------------------------
module current_autorange_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] current_ua, [25:24] forced_range, [31:26] zero
  input  logic [cac_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] action
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] active_range, [4:2] shunt_select, [20:5] cal_word, [21] switched,
  // [23:22] zero
  output logic [cac_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [cac_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cac_pkg::LimitW-1:0]    cfg_data_i
);
  import cac_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t res;

  cac_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cac_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .force_range_i  (s_axis_tuser),
    .current_ua_i   (s_axis_tdata[CurW-1:0]),
    .forced_range_i (s_axis_tdata[CurW+RangeW-1:CurW]),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_o         (item)
  );

  cac_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, res};

endmodule

// ===== rtl/core/cac_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autoranger configuration registers
// Thresholds, sample count and calibration words, written by index.
// ----------------------------------------------------------------------------
module cac_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cac_pkg::LimitW-1:0]   cfg_data_i,
  output cac_pkg::cfg_t                cfg_o
);
  import cac_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UP_LIMIT_LOW:    cfg_d.up_limit_low    = cfg_data_i;
        CFG_UP_LIMIT_MID:    cfg_d.up_limit_mid    = cfg_data_i;
        CFG_DOWN_LIMIT_MID:  cfg_d.down_limit_mid  = cfg_data_i;
        CFG_DOWN_LIMIT_HIGH: cfg_d.down_limit_high = cfg_data_i;
        CFG_SAMPLES_NEEDED:  cfg_d.samples_needed  = cfg_data_i[CountW-1:0];
        CFG_CAL_WORD_LOW:    cfg_d.cal_word_low    = cfg_data_i[CalW-1:0];
        CFG_CAL_WORD_MID:    cfg_d.cal_word_mid    = cfg_data_i[CalW-1:0];
        CFG_CAL_WORD_HIGH:   cfg_d.cal_word_high   = cfg_data_i[CalW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_limit_low    <= UpLimitLowRst;
      cfg_q.up_limit_mid    <= UpLimitMidRst;
      cfg_q.down_limit_mid  <= DownLimitMidRst;
      cfg_q.down_limit_high <= DownLimitHighRst;
      cfg_q.samples_needed  <= SamplesNeededRst;
      cfg_q.cal_word_low    <= CalWordLowRst;
      cfg_q.cal_word_mid    <= CalWordMidRst;
      cfg_q.cal_word_high   <= CalWordHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/cac_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autoranger input stage
// Registers one sample or force transaction and its saturated magnitude.
// ----------------------------------------------------------------------------
module cac_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        force_range_i,
  input  logic [cac_pkg::CurW-1:0]    current_ua_i,
  input  logic [cac_pkg::RangeW-1:0]  forced_range_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output cac_pkg::item_t              item_o
);
  import cac_pkg::*;

  logic              valid_q, valid_d;
  item_t             item_q, item_d;
  logic [CurW-1:0]   neg_cur;
  logic [LimitW-1:0] mag;
  logic              load;

  always_comb begin
    neg_cur = -current_ua_i;
    if (!current_ua_i[CurW-1]) begin
      mag = current_ua_i[LimitW-1:0];
    end else if (neg_cur[CurW-1]) begin
      mag = MagMax;
    end else begin
      mag = neg_cur[LimitW-1:0];
    end
  end

  assign in_ready_o = !valid_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
    if (load) begin
      item_d.force_range  = force_range_i;
      item_d.magnitude    = mag;
      item_d.forced_range = forced_range_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/cac_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autoranger decision stage
// Holds range and out-of-band count, registers one result per transaction.
// ----------------------------------------------------------------------------
module cac_decide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cac_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  cac_pkg::item_t item_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output cac_pkg::result_t res_o
);
  import cac_pkg::*;

  range_e            range_q, range_d;
  logic [CountW-1:0] count_q, count_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;
  logic [CountW-1:0] count_inc;
  logic              out_of_band;
  logic              move;
  range_e            target;
  logic              fire;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign count_inc    = count_q + 1'b1;
  assign move         = out_of_band && (count_inc >= cfg_i.samples_needed);

  always_comb begin
    out_of_band = 1'b0;
    target      = range_q;
    case (range_q)
      RANGE_LOW: begin
        out_of_band = item_i.magnitude > cfg_i.up_limit_low;
        target      = RANGE_MID;
      end
      RANGE_MID: begin
        if (item_i.magnitude > cfg_i.up_limit_mid) begin
          out_of_band = 1'b1;
          target      = RANGE_HIGH;
        end else if (item_i.magnitude < cfg_i.down_limit_mid) begin
          out_of_band = 1'b1;
          target      = RANGE_LOW;
        end
      end
      default: begin
        out_of_band = item_i.magnitude < cfg_i.down_limit_high;
        target      = RANGE_MID;
      end
    endcase
  end

  always_comb begin
    range_d     = range_q;
    count_d     = count_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (item_ready_o) begin
      res_valid_d = item_valid_i;
    end
    if (fire) begin
      res_d.switched = 1'b0;
      if (item_i.force_range) begin
        if (item_i.forced_range <= RANGE_HIGH) begin
          range_d = range_e'(item_i.forced_range);
          count_d = '0;
        end
      end else if (move) begin
        range_d        = target;
        count_d        = '0;
        res_d.switched = 1'b1;
      end else if (out_of_band) begin
        count_d = count_inc;
      end else begin
        count_d = '0;
      end
      res_d.active_range = range_d;
      case (range_d)
        RANGE_LOW: begin
          res_d.shunt_select = 3'b001;
          res_d.cal_word     = cfg_i.cal_word_low;
        end
        RANGE_MID: begin
          res_d.shunt_select = 3'b010;
          res_d.cal_word     = cfg_i.cal_word_mid;
        end
        default: begin
          res_d.shunt_select = 3'b100;
          res_d.cal_word     = cfg_i.cal_word_high;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q     <= RANGE_HIGH;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      range_q     <= range_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
